// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros used by the sequencer RTL
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== rtl/ptls_pkg.sv =====
// ----------------------------------------------------------------------------
// ptls_pkg
// Types and constants of the pulse-train LED sequencer.
// ----------------------------------------------------------------------------
package ptls_pkg;

    localparam int LEDS_PER_WELL = 3;
    localparam int WELL_COUNT    = 96;
    localparam int CHANNELS      = LEDS_PER_WELL * WELL_COUNT;
    localparam int CH_W          = $clog2(CHANNELS);

    localparam int KIND_W  = 2;
    localparam int LED_W   = 2;
    localparam int WELL_W  = 7;
    localparam int TIME_W  = 16;
    localparam int AMP_W   = 8;
    localparam int PHASE_W = 3;

    typedef enum logic [KIND_W-1:0] {
        KIND_TICK    = 2'd0,
        KIND_ENABLE  = 2'd1,
        KIND_DISABLE = 2'd2,
        KIND_NONE    = 2'd3
    } t_kind;

    typedef enum logic [PHASE_W-1:0] {
        PH_START    = 3'd0,
        PH_HIGH_ON  = 3'd1,
        PH_HIGH_OFF = 3'd2,
        PH_LOW      = 3'd3,
        PH_DONE     = 3'd4
    } t_phase;

    typedef struct packed {
        logic [PHASE_W-1:0] phase;
        logic [TIME_W-1:0]  tick;
        logic [TIME_W-1:0]  pulse;
        logic               en;
    } t_chan_word;

    localparam int WORD_W = $bits(t_chan_word);

endpackage

// ===== rtl/ptls_ram.sv =====
// ----------------------------------------------------------------------------
// ptls_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ptls_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/pulse_train_led_sequencer.sv =====
// ----------------------------------------------------------------------------
// pulse_train_led_sequencer: per-channel pulse-train sequencer for an LED array
// Per word: read, evaluate, run the sub-pulse modulo on a 16-step restoring
// divider when needed, then strobe; an out-of-range address skips to the strobe.
// Busy spans all. Reset: a sweep writes channel RAM to its reset word, busy high.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pulse_train_led_sequencer (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [ptls_pkg::KIND_W-1:0]   i_kind,
    input  logic [ptls_pkg::LED_W-1:0]    i_led_index,
    input  logic [ptls_pkg::WELL_W-1:0]   i_well_index,
    input  logic [ptls_pkg::TIME_W-1:0]   i_start_delay,
    input  logic [ptls_pkg::TIME_W-1:0]   i_pulse_high_time,
    input  logic [ptls_pkg::TIME_W-1:0]   i_pulse_low_time,
    input  logic [ptls_pkg::TIME_W-1:0]   i_sub_high_time,
    input  logic [ptls_pkg::TIME_W-1:0]   i_sub_low_time,
    input  logic [ptls_pkg::TIME_W-1:0]   i_pulse_total,
    input  logic [ptls_pkg::AMP_W-1:0]    i_amplitude,
    output logic                          o_strobe,
    output logic [ptls_pkg::AMP_W-1:0]    o_intensity,
    output logic                          o_finished
);

    import ptls_pkg::*;

    // Sequencer: sweep the RAM after reset, then per word read, evaluate,
    // optionally run the divider, and write back with the result.
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_EVAL,
        ST_DIV,
        ST_FIN
    } t_state;

    localparam int ITER_W = $clog2(TIME_W);
    localparam int PER_W  = TIME_W + 1;

    t_state              r_state,  n_state;
    logic [CH_W-1:0]     r_addr,   n_addr;    // clear sweep / channel of the word
    logic                r_oor,    n_oor;     // address out of range
    logic [KIND_W-1:0]   r_kind,   n_kind;
    logic [TIME_W-1:0]   r_start,  n_start;
    logic [TIME_W-1:0]   r_high,   n_high;
    logic [TIME_W-1:0]   r_low,    n_low;
    logic [TIME_W-1:0]   r_sub_h,  n_sub_h;
    logic [TIME_W-1:0]   r_sub_l,  n_sub_l;
    logic [TIME_W-1:0]   r_total,  n_total;
    logic [AMP_W-1:0]    r_amp,    n_amp;
    t_chan_word          r_word,   n_word;    // channel word as read
    logic [PER_W-1:0]    r_period, n_period;  // sub-pulse period
    logic [PER_W-1:0]    r_rem,    n_rem;     // divider remainder
    logic [TIME_W-1:0]   r_dvd,    n_dvd;     // divider dividend shift register
    logic [ITER_W-1:0]   r_iter,   n_iter;
    logic                r_div_ran, n_div_ran;
    logic                r_strobe, n_strobe;
    logic [AMP_W-1:0]    r_intensity, n_intensity;
    logic                r_finished,  n_finished;

    // RAM ports
    logic                ram_we;
    logic [CH_W-1:0]     ram_waddr;
    t_chan_word          ram_wdata;
    logic [CH_W-1:0]     ram_raddr;
    logic [WORD_W-1:0]   ram_rdata;

    logic                accept;
    logic                in_range;
    logic [CH_W-1:0]     in_ch;
    logic [TIME_W-1:0]   cnt;          // tick count after the increment
    logic [PER_W:0]      div_shift;    // partial remainder with the next bit in
    logic [PER_W:0]      div_trial;
    logic [TIME_W-1:0]   pulse_inc;
    logic                hit;          // sub-pulse modulo matched
    t_chan_word          new_word;
    logic                led_high;

    assign busy   = (r_state != ST_IDLE);
    assign accept = start && !busy;

    assign in_range = (int'(i_led_index) < LEDS_PER_WELL) &&
                      (int'(i_well_index) < WELL_COUNT);
    assign in_ch    = CH_W'(int'(i_well_index) * LEDS_PER_WELL + int'(i_led_index));

    assign cnt       = r_word.tick + TIME_W'(1);
    assign pulse_inc = r_word.pulse + TIME_W'(1);

    // One restoring divider step: shift in the next dividend bit, try subtract.
    assign div_shift = {r_rem, r_dvd[TIME_W-1]};
    assign div_trial = div_shift - {1'b0, r_period};

    assign hit = r_div_ran &&
                 ((r_word.phase == PH_HIGH_ON)  ? (r_rem == {1'b0, r_sub_h}) :
                  (r_word.phase == PH_HIGH_OFF) ? (r_rem == '0) : 1'b0);

    // Next channel word and LED level of a finished item
    always_comb begin
        new_word = r_word;
        led_high = 1'b0;
        case (r_kind)
            KIND_TICK: begin
                new_word.tick = cnt;
                case (r_word.phase)
                    PH_START: begin
                        if (cnt >= r_start) begin
                            new_word.phase = PH_HIGH_ON;
                            new_word.tick  = '0;
                            led_high       = 1'b1;
                        end
                    end
                    PH_HIGH_ON: begin
                        if (cnt >= r_high) begin
                            new_word.phase = PH_LOW;
                            new_word.tick  = '0;
                        end else if (hit) begin
                            new_word.phase = PH_HIGH_OFF;
                        end else begin
                            led_high = 1'b1;
                        end
                    end
                    PH_HIGH_OFF: begin
                        if (cnt >= r_high) begin
                            new_word.phase = PH_LOW;
                            new_word.tick  = '0;
                        end else if (hit) begin
                            new_word.phase = PH_HIGH_ON;
                            led_high       = 1'b1;
                        end
                    end
                    PH_LOW: begin
                        if (cnt >= r_low) begin
                            new_word.pulse = pulse_inc;
                            new_word.tick  = '0;
                            if (pulse_inc >= r_total) begin
                                new_word.phase = PH_DONE;
                            end else begin
                                new_word.phase = PH_HIGH_ON;
                                led_high       = 1'b1;
                            end
                        end
                    end
                    default: begin
                        // done and unused codes: only the tick count moves
                    end
                endcase
            end
            KIND_ENABLE:  new_word.en = 1'b1;
            KIND_DISABLE: new_word.en = 1'b0;
            default: begin
                // unused kind: leave the channel as it is
            end
        endcase
    end

    // RAM access: sweep writes the reset word, the final step writes back
    always_comb begin
        ram_raddr = in_ch;
        if (r_state == ST_CLEAR) begin
            ram_we          = 1'b1;
            ram_waddr       = r_addr;
            ram_wdata.phase = PH_START;
            ram_wdata.tick  = '0;
            ram_wdata.pulse = '0;
            ram_wdata.en    = 1'b1;
        end else begin
            ram_we    = (r_state == ST_FIN) && !r_oor;
            ram_waddr = r_addr;
            ram_wdata = new_word;
        end
    end

    // Sequencer next state
    always_comb begin
        n_state     = r_state;
        n_addr      = r_addr;
        n_oor       = r_oor;
        n_kind      = r_kind;
        n_start     = r_start;
        n_high      = r_high;
        n_low       = r_low;
        n_sub_h     = r_sub_h;
        n_sub_l     = r_sub_l;
        n_total     = r_total;
        n_amp       = r_amp;
        n_word      = r_word;
        n_period    = r_period;
        n_rem       = r_rem;
        n_dvd       = r_dvd;
        n_iter      = r_iter;
        n_div_ran   = r_div_ran;
        n_strobe    = 1'b0;
        n_intensity = r_intensity;
        n_finished  = r_finished;
        case (r_state)
            ST_CLEAR: begin
                n_addr = r_addr + CH_W'(1);
                if (r_addr == CH_W'(CHANNELS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    // capture the input word; the RAM read is in flight
                    n_addr  = in_ch;
                    n_oor   = !in_range;
                    n_kind  = i_kind;
                    n_start = i_start_delay;
                    n_high  = i_pulse_high_time;
                    n_low   = i_pulse_low_time;
                    n_sub_h = i_sub_high_time;
                    n_sub_l = i_sub_low_time;
                    n_total = i_pulse_total;
                    n_amp   = i_amplitude;
                    n_state = in_range ? ST_READ : ST_FIN;
                end
            end
            ST_READ: begin
                n_word    = t_chan_word'(ram_rdata);
                n_period  = {1'b0, r_sub_h} + {1'b0, r_sub_l};
                n_div_ran = 1'b0;
                n_state   = ST_EVAL;
            end
            ST_EVAL: begin
                // run the modulo only where the high phase can toggle
                if ((r_kind == KIND_TICK) &&
                    ((r_word.phase == PH_HIGH_ON) || (r_word.phase == PH_HIGH_OFF)) &&
                    (cnt < r_high) && (r_period != '0)) begin
                    n_rem     = '0;
                    n_dvd     = cnt;
                    n_iter    = ITER_W'(TIME_W - 1);
                    n_div_ran = 1'b1;
                    n_state   = ST_DIV;
                end else begin
                    n_state = ST_FIN;
                end
            end
            ST_DIV: begin
                n_rem  = div_trial[PER_W] ? div_shift[PER_W-1:0] : div_trial[PER_W-1:0];
                n_dvd  = {r_dvd[TIME_W-2:0], 1'b0};
                n_iter = r_iter - ITER_W'(1);
                if (r_iter == '0) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                // drive the result word and drop back to idle
                n_strobe = 1'b1;
                if (r_oor) begin
                    n_intensity = '0;
                    n_finished  = 1'b0;
                end else begin
                    n_intensity = (led_high && r_word.en) ? r_amp : '0;
                    n_finished  = (new_word.phase == PH_DONE);
                end
                n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_CLEAR;
            r_addr   <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_addr   <= n_addr;
            r_strobe <= n_strobe;
        end
        r_oor       <= n_oor;
        r_kind      <= n_kind;
        r_start     <= n_start;
        r_high      <= n_high;
        r_low       <= n_low;
        r_sub_h     <= n_sub_h;
        r_sub_l     <= n_sub_l;
        r_total     <= n_total;
        r_amp       <= n_amp;
        r_word      <= n_word;
        r_period    <= n_period;
        r_rem       <= n_rem;
        r_dvd       <= n_dvd;
        r_iter      <= n_iter;
        r_div_ran   <= n_div_ran;
        r_intensity <= n_intensity;
        r_finished  <= n_finished;
    end

    ptls_ram #(
        .WIDTH (WORD_W),
        .DEPTH (CHANNELS)
    ) u_chan_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_strobe    = r_strobe;
    assign o_intensity = r_intensity;
    assign o_finished  = r_finished;

    // A finished write-back always yields exactly one result word.
    `ASSERT_NEXT(a_fin_strobe, i_clk, i_rst_n, r_state == ST_FIN, r_strobe)
    // An accepted word keeps the block busy in the next cycle.
    `ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, accept, busy)
    // The divider only runs with a nonzero period.
    `ASSERT_IMPLY(a_div_period, i_clk, i_rst_n, r_state == ST_DIV, r_period != '0)
    // A done channel never drives its LED.
    `ASSERT_IMPLY(a_done_dark, i_clk, i_rst_n, r_strobe && r_finished, r_intensity == '0)

endmodule

// ===== dv/tb_pulse_train_led_sequencer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pulse_train_led_sequencer: self-checking bench for the LED pulse sequencer
// A short table of hand-picked words runs first: address extremes, every kind,
// zero and maximum timing words, a pulse total of zero and a channel driven to
// done. Random pulse trains on a rotating set of channels follow, mixed with
// noise words. Every accepted word is run through a local model of all 288
// channels, and each strobed result is checked against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_pulse_train_led_sequencer;

    import ptls_pkg::*;

    localparam int DIR_ROWS     = 25;
    localparam int RANDOM_WORDS = 1450;
    localparam int SLOTS        = 4;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int MAX_REPORTS  = 10;

    // One command word, laid out field by field as the ports take it.
    typedef struct packed {
        t_kind               kind;
        logic [LED_W-1:0]    led;
        logic [WELL_W-1:0]   well;
        logic [TIME_W-1:0]   sdly;
        logic [TIME_W-1:0]   hi;
        logic [TIME_W-1:0]   lo;
        logic [TIME_W-1:0]   sh;
        logic [TIME_W-1:0]   sl;
        logic [TIME_W-1:0]   tot;
        logic [AMP_W-1:0]    amp;
    } t_word;

    // Drive level and finished flag expected for one word.
    typedef struct packed {
        logic [AMP_W-1:0] level;
        logic             fin;
    } t_drive;

    // Row of the directed table; pin marks a row whose result is typed in.
    typedef struct packed {
        t_word            w;
        logic             pin;
        logic [AMP_W-1:0] level;
        logic             fin;
    } t_row;

    // ------------------------------------------------------------------------
    // Clock, reset and the DUT
    // ------------------------------------------------------------------------
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic start   = 1'b0;
    logic busy;

    t_word            drv     = '0;
    logic             pin_on  = 1'b0;
    logic [AMP_W-1:0] pin_lvl = '0;
    logic             pin_fin = 1'b0;

    logic             o_strobe;
    logic [AMP_W-1:0] o_intensity;
    logic             o_finished;

    always #5 i_clk = ~i_clk;

    pulse_train_led_sequencer dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_kind            (drv.kind),
        .i_led_index       (drv.led),
        .i_well_index      (drv.well),
        .i_start_delay     (drv.sdly),
        .i_pulse_high_time (drv.hi),
        .i_pulse_low_time  (drv.lo),
        .i_sub_high_time   (drv.sh),
        .i_sub_low_time    (drv.sl),
        .i_pulse_total     (drv.tot),
        .i_amplitude       (drv.amp),
        .o_strobe          (o_strobe),
        .o_intensity       (o_intensity),
        .o_finished        (o_finished)
    );

    // ------------------------------------------------------------------------
    // Channel model: one copy of the per-channel state, indexed well*3 + led
    // ------------------------------------------------------------------------
    t_phase            chan_phase   [CHANNELS];
    logic [TIME_W-1:0] chan_ticks   [CHANNELS];
    logic [TIME_W-1:0] chan_pulses  [CHANNELS];
    logic              chan_enabled [CHANNELS];

    t_drive expected_drive [$];

    int mismatches    = 0;
    int words_taken   = 0;
    int ticks_taken   = 0;
    int lit_ticks     = 0;
    int finished_seen = 0;
    int results_seen  = 0;
    int burst_left    = 0;
    int cycle_count   = 0;

    // Advance the addressed channel by one word and work out its drive level.
    task automatic advance_channel(input t_word w, output logic [AMP_W-1:0] lvl,
                                   output logic fin);
        int unsigned        ch;
        logic [TIME_W-1:0]  cnt;
        logic [TIME_W:0]    period;
        logic               lit;
        lvl = '0;
        fin = 1'b0;
        lit = 1'b0;
        // Drop words aimed past the LED array; they report all zeros.
        if (w.led >= LEDS_PER_WELL || w.well >= WELL_COUNT)
            return;
        ch = w.well * LEDS_PER_WELL + w.led;
        case (w.kind)
            KIND_TICK: begin
                // Bump the tick count first; every phase compares the new value.
                cnt = chan_ticks[ch] + 1'b1;
                chan_ticks[ch] = cnt;
                period = {1'b0, w.sh} + {1'b0, w.sl};
                case (chan_phase[ch])
                    PH_START: begin
                        if (cnt >= w.sdly) begin
                            chan_phase[ch] = PH_HIGH_ON;
                            chan_ticks[ch] = '0;
                            lit = 1'b1;
                        end
                    end
                    PH_HIGH_ON: begin
                        if (cnt >= w.hi) begin
                            chan_phase[ch] = PH_LOW;
                            chan_ticks[ch] = '0;
                        end else if (period != 0 &&
                                     ({1'b0, cnt} % period) == {1'b0, w.sh}) begin
                            chan_phase[ch] = PH_HIGH_OFF;
                        end else begin
                            // A zero sub-pulse period never toggles: hold high.
                            lit = 1'b1;
                        end
                    end
                    PH_HIGH_OFF: begin
                        if (cnt >= w.hi) begin
                            chan_phase[ch] = PH_LOW;
                            chan_ticks[ch] = '0;
                        end else if (period != 0 && ({1'b0, cnt} % period) == 0) begin
                            chan_phase[ch] = PH_HIGH_ON;
                            lit = 1'b1;
                        end
                    end
                    PH_LOW: begin
                        if (cnt >= w.lo) begin
                            chan_pulses[ch] = chan_pulses[ch] + 1'b1;
                            chan_ticks[ch] = '0;
                            if (chan_pulses[ch] >= w.tot) begin
                                chan_phase[ch] = PH_DONE;
                            end else begin
                                chan_phase[ch] = PH_HIGH_ON;
                                lit = 1'b1;
                            end
                        end
                    end
                    default: ;
                endcase
                if (lit && chan_enabled[ch])
                    lvl = w.amp;
            end
            KIND_ENABLE:  chan_enabled[ch] = 1'b1;
            KIND_DISABLE: chan_enabled[ch] = 1'b0;
            default: ;
        endcase
        fin = (chan_phase[ch] == PH_DONE);
    endtask

    // ------------------------------------------------------------------------
    // Result check and word capture, both on the rising edge
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : watch_results
        t_drive           want;
        logic [AMP_W-1:0] p_lvl;
        logic             p_fin;
        // Check the strobe before taking a new word: no word's result can
        // show up on the edge that accepts it.
        if (i_rst_n && o_strobe) begin
            results_seen++;
            if (expected_drive.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("[%0t] unexpected result: intensity %0d finished %0b",
                             $time, o_intensity, o_finished);
            end else begin
                want = expected_drive.pop_front();
                if (o_intensity !== want.level || o_finished !== want.fin) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display(
                            "[%0t] mismatch: intensity exp %0d got %0d, finished exp %0b got %0b",
                            $time, want.level, o_intensity, want.fin, o_finished);
                end
            end
        end
        if (i_rst_n && start && !busy) begin
            advance_channel(drv, p_lvl, p_fin);
            words_taken++;
            if (drv.kind == KIND_TICK)
                ticks_taken++;
            // Pinned rows carry their own answer; the model still advances.
            if (pin_on)
                expected_drive.push_back('{level: pin_lvl, fin: pin_fin});
            else
                expected_drive.push_back('{level: p_lvl, fin: p_fin});
            if ((pin_on ? pin_lvl : p_lvl) != 0)
                lit_ticks++;
            if (pin_on ? pin_fin : p_fin)
                finished_seen++;
        end
    end

    // Watchdog: stop a hung run well past the slowest correct one.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("watchdog expired after %0d cycles", CYCLE_LIMIT);
            $display("** pulse_train_led_sequencer: FAILED **");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Driving
    // ------------------------------------------------------------------------

    // Present a word and hold it until the block takes it. Start stays high on
    // return so a back-to-back word needs no second assignment in this step.
    task automatic send_word(input t_word w, input logic pin, input logic [AMP_W-1:0] lvl,
                             input logic fin);
        drv     <= w;
        pin_on  <= pin;
        pin_lvl <= lvl;
        pin_fin <= fin;
        start   <= 1'b1;
        @(posedge i_clk);
        while (busy !== 1'b0)
            @(posedge i_clk);
    endtask

    // Idle the sender for a random stretch: mostly none, sometimes a short gap,
    // now and then a long pause. Bursts skip idling altogether.
    task automatic idle_gap();
        int r;
        int n;
        r = $urandom_range(0, 99);
        if (burst_left > 0) begin
            burst_left--;
            n = 0;
        end else if (r < 60) begin
            n = 0;
        end else if (r < 90) begin
            n = $urandom_range(1, 3);
        end else begin
            n = $urandom_range(8, 40);
        end
        if (n > 0) begin
            start <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // Drop start and wait until every predicted result has come back. Wait on
    // the clock first so the last accepted word is already queued.
    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (expected_drive.size() != 0)
            @(posedge i_clk);
    endtask

    // Random channels under test, each with its own timing words.
    t_word slot_cfg  [SLOTS];
    int    slot_left [SLOTS] = '{default: 0};
    int    next_ch = 0;

    function automatic t_word noise_word();
        t_word w;
        w.kind = t_kind'($urandom_range(0, 3));
        w.led  = LED_W'($urandom_range(0, LEDS_PER_WELL - 1));
        w.well = WELL_W'($urandom_range(0, WELL_COUNT - 1));
        w.sdly = TIME_W'($urandom);
        w.hi   = TIME_W'($urandom);
        w.lo   = TIME_W'($urandom);
        w.sh   = TIME_W'($urandom);
        w.sl   = TIME_W'($urandom);
        w.tot  = TIME_W'($urandom);
        w.amp  = AMP_W'($urandom);
        return w;
    endfunction

    // Build the next random word: mostly ticks that walk a slot's channel
    // through its pulse train, plus flag changes, idle kinds, stray
    // addresses and fully random ticks.
    task automatic pick_word(output t_word w);
        int r;
        int s;
        s = $urandom_range(0, SLOTS - 1);
        if (slot_left[s] == 0) begin
            // Move the slot to a fresh channel; a stride of 37 visits all 288.
            slot_cfg[s].led  = LED_W'(next_ch % LEDS_PER_WELL);
            slot_cfg[s].well = WELL_W'(next_ch / LEDS_PER_WELL);
            next_ch = (next_ch + 37) % CHANNELS;
            slot_cfg[s].sdly = TIME_W'($urandom_range(0, 4));
            slot_cfg[s].hi   = TIME_W'($urandom_range(0, 12));
            slot_cfg[s].lo   = TIME_W'($urandom_range(0, 4));
            slot_cfg[s].sh   = TIME_W'($urandom_range(0, 4));
            slot_cfg[s].sl   = TIME_W'($urandom_range(0, 4));
            slot_cfg[s].tot  = TIME_W'($urandom_range(0, 4));
            // Now and then stretch the high phase with wide sub-pulse words.
            if ($urandom_range(0, 5) == 0) begin
                slot_cfg[s].hi = TIME_W'($urandom);
                slot_cfg[s].sh = TIME_W'($urandom);
                slot_cfg[s].sl = TIME_W'($urandom);
            end
            if ($urandom_range(0, 9) == 0)
                slot_cfg[s].sdly = TIME_W'($urandom_range(0, 40));
            slot_left[s] = $urandom_range(15, 60);
        end
        w     = slot_cfg[s];
        w.amp = AMP_W'($urandom);
        r     = $urandom_range(0, 99);
        if (r < 78) begin
            w.kind = KIND_TICK;
            slot_left[s]--;
            // Break the train once in a while with different high timing.
            if (r < 3)
                w.hi = TIME_W'($urandom_range(0, 12));
        end else if (r < 85) begin
            w.kind = ($urandom_range(0, 9) < 4) ? KIND_DISABLE : KIND_ENABLE;
        end else if (r < 88) begin
            w.kind = KIND_NONE;
        end else if (r < 93) begin
            w = noise_word();
            if ($urandom_range(0, 1))
                w.led = 2'd3;
            else
                w.well = WELL_W'($urandom_range(WELL_COUNT, 127));
        end else begin
            w = noise_word();
            w.kind = KIND_TICK;
        end
    endtask

    // Directed words. Pinned rows have results that read straight off the
    // rules; the rest are left to the channel model.
    t_row plan [DIR_ROWS] = '{
        // fresh channel, no delay: lit at once
        '{'{KIND_TICK,    2'd0, 7'd0,   16'd0,     16'hFFFF, 16'd0, 16'd0,
            16'd0,     16'd1, 8'hFF}, 1'b1, 8'hFF, 1'b0},
        '{'{KIND_NONE,    2'd0, 7'd0,   16'd0,     16'hFFFF, 16'd0, 16'd0,
            16'd0,     16'd1, 8'hFF}, 1'b1, 8'h00, 1'b0},
        '{'{KIND_DISABLE, 2'd0, 7'd0,   16'd0,     16'hFFFF, 16'd0, 16'd0,
            16'd0,     16'd1, 8'hFF}, 1'b1, 8'h00, 1'b0},
        // high but disabled: dark
        '{'{KIND_TICK,    2'd0, 7'd0,   16'd0,     16'hFFFF, 16'd0, 16'd0,
            16'd0,     16'd1, 8'hAA}, 1'b1, 8'h00, 1'b0},
        '{'{KIND_ENABLE,  2'd0, 7'd0,   16'd0,     16'hFFFF, 16'd0, 16'd0,
            16'd0,     16'd1, 8'hFF}, 1'b1, 8'h00, 1'b0},
        '{'{KIND_TICK,    2'd0, 7'd0,   16'd0,     16'hFFFF, 16'd0, 16'd0,
            16'd0,     16'd1, 8'h55}, 1'b0, 8'h00, 1'b0},
        // addresses past the array
        '{'{KIND_TICK,    2'd3, 7'd0,   16'hFFFF,  16'hFFFF, 16'hFFFF, 16'hFFFF,
            16'hFFFF, 16'hFFFF, 8'hFF}, 1'b1, 8'h00, 1'b0},
        '{'{KIND_ENABLE,  2'd2, 7'd127, 16'd0,     16'd0,    16'd0, 16'd0,
            16'd0,     16'd0, 8'hFF}, 1'b1, 8'h00, 1'b0},
        '{'{KIND_DISABLE, 2'd1, 7'd96,  16'd0,     16'd0,    16'd0, 16'd0,
            16'd0,     16'd0, 8'hFF}, 1'b1, 8'h00, 1'b0},
        // longest start delay: still waiting
        '{'{KIND_TICK,    2'd2, 7'd95,  16'hFFFF,  16'd0,    16'd0, 16'd0,
            16'd0,     16'd0, 8'hFF}, 1'b1, 8'h00, 1'b0},
        // pulse total of zero: done after the first low phase
        '{'{KIND_TICK,    2'd1, 7'd1,   16'd0,     16'd1,    16'd0, 16'd0,
            16'd0,     16'd0, 8'h80}, 1'b1, 8'h80, 1'b0},
        '{'{KIND_TICK,    2'd1, 7'd1,   16'd0,     16'd1,    16'd0, 16'd0,
            16'd0,     16'd0, 8'h80}, 1'b0, 8'h00, 1'b0},
        '{'{KIND_TICK,    2'd1, 7'd1,   16'd0,     16'd1,    16'd0, 16'd0,
            16'd0,     16'd0, 8'h80}, 1'b1, 8'h00, 1'b1},
        '{'{KIND_TICK,    2'd1, 7'd1,   16'd0,     16'd1,    16'd0, 16'd0,
            16'd0,     16'd0, 8'h80}, 1'b1, 8'h00, 1'b1},
        '{'{KIND_DISABLE, 2'd1, 7'd1,   16'd0,     16'd1,    16'd0, 16'd0,
            16'd0,     16'd0, 8'h80}, 1'b1, 8'h00, 1'b1},
        // full train with sub-pulse toggling, start delay 2, one pulse
        '{'{KIND_TICK,    2'd2, 7'd5,   16'd2,     16'd4,    16'd1, 16'd1,
            16'd2,     16'd1, 8'hC3}, 1'b0, 8'h00, 1'b0},
        '{'{KIND_TICK,    2'd2, 7'd5,   16'd2,     16'd4,    16'd1, 16'd1,
            16'd2,     16'd1, 8'hC3}, 1'b0, 8'h00, 1'b0},
        '{'{KIND_TICK,    2'd2, 7'd5,   16'd2,     16'd4,    16'd1, 16'd1,
            16'd2,     16'd1, 8'hC3}, 1'b0, 8'h00, 1'b0},
        '{'{KIND_TICK,    2'd2, 7'd5,   16'd2,     16'd4,    16'd1, 16'd1,
            16'd2,     16'd1, 8'hC3}, 1'b0, 8'h00, 1'b0},
        '{'{KIND_TICK,    2'd2, 7'd5,   16'd2,     16'd4,    16'd1, 16'd1,
            16'd2,     16'd1, 8'hC3}, 1'b0, 8'h00, 1'b0},
        '{'{KIND_TICK,    2'd2, 7'd5,   16'd2,     16'd4,    16'd1, 16'd1,
            16'd2,     16'd1, 8'hC3}, 1'b0, 8'h00, 1'b0},
        '{'{KIND_TICK,    2'd2, 7'd5,   16'd2,     16'd4,    16'd1, 16'd1,
            16'd2,     16'd1, 8'hC3}, 1'b0, 8'h00, 1'b0},
        // widest sub-pulse words: the 17-bit period
        '{'{KIND_TICK,    2'd0, 7'd64,  16'd0,     16'hFFFF, 16'd0, 16'hFFFF,
            16'hFFFF,  16'd5, 8'h01}, 1'b0, 8'h00, 1'b0},
        '{'{KIND_TICK,    2'd0, 7'd64,  16'd0,     16'hFFFF, 16'd0, 16'hFFFF,
            16'hFFFF,  16'd5, 8'h01}, 1'b0, 8'h00, 1'b0},
        // zero sub-pulse on time
        '{'{KIND_TICK,    2'd1, 7'd64,  16'd0,     16'd10,   16'd0, 16'd0,
            16'd3,     16'd2, 8'h7E}, 1'b0, 8'h00, 1'b0}
    };

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin
        t_word w;
        int    i;
        // Load the model's reset state: all channels in start, enabled.
        for (i = 0; i < CHANNELS; i++) begin
            chan_phase[i]   = PH_START;
            chan_ticks[i]   = '0;
            chan_pulses[i]  = '0;
            chan_enabled[i] = 1'b1;
        end
        // Hold reset, then release; the block clears its RAM with busy high.
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (i = 0; i < DIR_ROWS; i++) begin
            send_word(plan[i].w, plan[i].pin, plan[i].level, plan[i].fin);
            idle_gap();
        end
        drain();

        for (i = 0; i < RANDOM_WORDS; i++) begin
            // Halfway through, stall the sender until everything is back.
            if (i == RANDOM_WORDS / 2)
                drain();
            if (i % 200 == 100)
                burst_left = 40;
            pick_word(w);
            send_word(w, 1'b0, '0, 1'b0);
            idle_gap();
        end

        // Let the last results arrive, then watch a while for strays.
        drain();
        repeat (40) @(posedge i_clk);

        $display("ran %0d words (%0d ticks), %0d lit, %0d with the channel done",
                 words_taken, ticks_taken, lit_ticks, finished_seen);
        $display("checked %0d results, %0d mismatches", results_seen, mismatches);
        if (mismatches == 0 && expected_drive.size() == 0)
            $display("** pulse_train_led_sequencer: PASSED **");
        else
            $display("** pulse_train_led_sequencer: FAILED **");
        $finish;
    end

endmodule
